### rtl/lapp_pkg.sv
`default_nettype none
package lapp_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 800;
  localparam int unsigned SCREEN_HEIGHT_DEF = 600;

  localparam int unsigned CW = 32;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned BW = 33;
  localparam int unsigned PW = 2 * BW;
  localparam int unsigned XW = 50;

  localparam int unsigned QB        = 40;
  localparam int unsigned Q_FRAC    = 15;
  localparam int unsigned DIV_STEPS = 2;

  localparam logic signed [XW-1:0] NEAR_Z = XW'(10737418);

  typedef enum logic [2:0] {
    REG_CAM_X  = 3'd0,
    REG_CAM_Y  = 3'd1,
    REG_CAM_Z  = 3'd2,
    REG_LOOK_X = 3'd3,
    REG_LOOK_Y = 3'd4,
    REG_LOOK_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_UP,
    ST_FIN
  } bstate_t;

  typedef struct packed {
    logic               ok;
    logic [2:0][BW-1:0] fwd;
    logic [2:0][BW-1:0] rgt;
    logic [2:0][BW-1:0] up;
  } basis_t;

endpackage
`default_nettype wire

### rtl/lapp_basis.sv
`default_nettype none
module lapp_basis (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [2:0][lapp_pkg::CW-1:0] cam,
  input  logic [2:0][lapp_pkg::CW-1:0] look,
  output logic                         busy,
  output lapp_pkg::basis_t             basis
);

  localparam int unsigned VW      = lapp_pkg::CW + 2;
  localparam int unsigned FB      = 30;
  localparam int unsigned NW      = 64;
  localparam int unsigned LW      = 32;
  localparam int unsigned DVW     = 2 * FB;
  localparam int unsigned CNTW    = $clog2(DVW);
  localparam int unsigned BW      = lapp_pkg::BW;
  localparam int unsigned PW      = lapp_pkg::PW;
  localparam logic [VW-1:0] ONE_Q  = VW'(1) << FB;
  localparam logic [VW-1:0] HALF_Q = VW'(1) << (FB - 1);
  localparam logic [CNTW-1:0] SQ_LAST = CNTW'(2);
  localparam logic [CNTW-1:0] RT_LAST = CNTW'(NW / 2 - 1);
  localparam logic [CNTW-1:0] DV_LAST = CNTW'(DVW - 1);
  localparam logic [CNTW-1:0] UP_LAST = CNTW'(3);
  localparam logic signed [PW-1:0] RND30 = PW'((64'd1 << FB) - 64'd1);

  lapp_pkg::bstate_t st_r, st_nxt;

  logic signed [VW-1:0] v_r   [3];
  logic signed [VW-1:0] dir_r [3];
  logic [NW-1:0]        acc_r;
  logic [NW-1:0]        root_r;
  logic [LW-1:0]        rem_r;
  logic [LW-1:0]        q_r;
  logic [DVW-1:0]       dvd_r;
  logic [CNTW-1:0]      cnt_r;
  logic [1:0]           comp_r;
  logic                 sel_r;
  logic                 ok_r;
  logic signed [BW-1:0] fwd_r [3];
  logic signed [BW-1:0] rgt_r [3];
  logic signed [BW-1:0] up_r  [3];
  logic signed [PW-1:0] p_r   [4];

  logic signed [VW-1:0] dir_c [3];
  logic [VW-1:0]        mag   [3];
  logic                 is_big;
  logic                 is_low;
  logic                 degen;
  logic [DVW-1:0]       sq;
  logic [6:0]           shamt;
  logic [NW-1:0]        bitv;
  logic [NW-1:0]        trial;
  logic                 sq_ge;
  logic [LW-1:0]        len;
  logic [LW:0]          rs;
  logic                 div_ge;
  logic [LW-1:0]        qfin;
  logic signed [BW-1:0] qres;
  logic [1:0]           nc;
  logic signed [BW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] pd;
  logic signed [PW-1:0] up_mid;
  logic signed [PW-1:0] a0;
  logic signed [PW-1:0] a1;
  logic signed [PW-1:0] a2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_c[i] = VW'($signed(look[i])) - VW'($signed(cam[i]));
      mag[i]   = v_r[i][VW-1] ? VW'(-v_r[i]) : VW'(v_r[i]);
    end
    degen  = (dir_c[0] == '0) && (dir_c[2] == '0);
    is_big = (mag[0] >= ONE_Q) || (mag[1] >= ONE_Q) || (mag[2] >= ONE_Q);
    is_low = (mag[0] < HALF_Q) && (mag[1] < HALF_Q) && (mag[2] < HALF_Q);
    sq     = DVW'(mag[cnt_r[1:0]][FB-1:0]) * DVW'(mag[cnt_r[1:0]][FB-1:0]);

    shamt = 7'(2 * (FB + 1)) - {cnt_r, 1'b0};
    bitv  = NW'(1) << shamt;
    trial = root_r + bitv;
    sq_ge = acc_r >= trial;

    len    = root_r[LW-1:0];
    rs     = {rem_r, dvd_r[DVW-1]};
    div_ge = rs >= {1'b0, len};
    qfin   = {q_r[LW-2:0], div_ge};
    qres   = v_r[comp_r][VW-1] ? -BW'(qfin) : BW'(qfin);
    nc     = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;

    case (cnt_r[1:0])
      2'd0: begin
        ma = fwd_r[1];
        mb = rgt_r[2];
      end
      2'd1: begin
        ma = fwd_r[2];
        mb = rgt_r[0];
      end
      2'd2: begin
        ma = fwd_r[0];
        mb = rgt_r[2];
      end
      default: begin
        ma = fwd_r[1];
        mb = rgt_r[0];
      end
    endcase
    pd = PW'(ma) * PW'(mb);

    up_mid = p_r[1] - p_r[2];
    a0 = p_r[0] + (p_r[0][PW-1] ? RND30 : '0);
    a1 = up_mid + (up_mid[PW-1] ? RND30 : '0);
    a2 = p_r[3] + (p_r[3][PW-1] ? RND30 : '0);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lapp_pkg::ST_IDLE:  st_nxt = lapp_pkg::ST_IDLE;
      lapp_pkg::ST_DIR:   st_nxt = degen ? lapp_pkg::ST_IDLE : lapp_pkg::ST_SHIFT;
      lapp_pkg::ST_SHIFT: if (!is_big && !is_low) st_nxt = lapp_pkg::ST_SQ;
      lapp_pkg::ST_SQ:    if (cnt_r == SQ_LAST) st_nxt = lapp_pkg::ST_SQRT;
      lapp_pkg::ST_SQRT:  if (cnt_r == RT_LAST) st_nxt = lapp_pkg::ST_DIV;
      lapp_pkg::ST_DIV: begin
        if (cnt_r == DV_LAST && comp_r == 2'd2) begin
          st_nxt = sel_r ? lapp_pkg::ST_UP : lapp_pkg::ST_SHIFT;
        end
      end
      lapp_pkg::ST_UP:    if (cnt_r == UP_LAST) st_nxt = lapp_pkg::ST_FIN;
      lapp_pkg::ST_FIN:   st_nxt = lapp_pkg::ST_IDLE;
      default:            st_nxt = lapp_pkg::ST_IDLE;
    endcase
    if (restart) st_nxt = lapp_pkg::ST_DIR;
  end

  always_comb begin
    busy = (st_r != lapp_pkg::ST_IDLE);
    basis.ok = ok_r;
    for (int i = 0; i < 3; i++) begin
      basis.fwd[i] = fwd_r[i];
      basis.rgt[i] = rgt_r[i];
      basis.up[i]  = up_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= lapp_pkg::ST_DIR;
      cnt_r  <= '0;
      comp_r <= '0;
      sel_r  <= 1'b0;
      ok_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r || (st_r == lapp_pkg::ST_DIV && cnt_r == DV_LAST)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (st_r != lapp_pkg::ST_DIV) begin
        comp_r <= '0;
      end else if (cnt_r == DV_LAST) begin
        comp_r <= comp_r + 2'd1;
      end
      if (st_r == lapp_pkg::ST_DIR) begin
        sel_r <= 1'b0;
        ok_r  <= !degen;
      end else if (st_r == lapp_pkg::ST_DIV && cnt_r == DV_LAST && comp_r == 2'd2) begin
        sel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      lapp_pkg::ST_DIR: begin
        for (int i = 0; i < 3; i++) begin
          dir_r[i] <= dir_c[i];
          v_r[i]   <= dir_c[i];
        end
      end
      lapp_pkg::ST_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (is_big) begin
            v_r[i] <= v_r[i][VW-1] ? VW'(-(mag[i] >> 1)) : VW'(mag[i] >> 1);
          end else if (is_low) begin
            v_r[i] <= v_r[i] <<< 1;
          end
        end
        acc_r <= '0;
      end
      lapp_pkg::ST_SQ: begin
        acc_r  <= acc_r + NW'(sq);
        root_r <= '0;
      end
      lapp_pkg::ST_SQRT: begin
        if (sq_ge) begin
          acc_r  <= acc_r - trial;
          root_r <= (root_r >> 1) + bitv;
        end else begin
          root_r <= root_r >> 1;
        end
        rem_r <= '0;
        q_r   <= '0;
        dvd_r <= {mag[0][FB-1:0], FB'(0)};
      end
      lapp_pkg::ST_DIV: begin
        if (cnt_r == DV_LAST) begin
          if (sel_r) begin
            rgt_r[comp_r] <= qres;
          end else begin
            fwd_r[comp_r] <= qres;
          end
          rem_r <= '0;
          q_r   <= '0;
          dvd_r <= {mag[nc][FB-1:0], FB'(0)};
          if (comp_r == 2'd2 && !sel_r) begin
            v_r[0] <= dir_r[2];
            v_r[1] <= '0;
            v_r[2] <= -dir_r[0];
          end
        end else begin
          rem_r <= div_ge ? LW'(rs - {1'b0, len}) : LW'(rs);
          q_r   <= qfin;
          dvd_r <= dvd_r << 1;
        end
      end
      lapp_pkg::ST_UP: begin
        p_r[cnt_r[1:0]] <= pd;
      end
      lapp_pkg::ST_FIN: begin
        up_r[0] <= BW'(a0 >>> FB);
        up_r[1] <= BW'(a1 >>> FB);
        up_r[2] <= -BW'(a2 >>> FB);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/look_at_perspective_projection_core.sv
`default_nettype none
// Look-at perspective projection, one world point per clock when not stalled or rebuilding
// the basis. Each beat on the in_ channel yields one beat on the out_ channel after five
// arithmetic stages, a 20 stage pipelined divider retiring two quotient bits per stage and
// one output register; stalls on out_ready hold items in place and bubbles are squeezed
// out. After reset and after every cfg_ write the camera basis is rebuilt by a serial unit
// (normalize shift, square-sum, bit-serial square root, bit-serial division, for forward
// and right in turn, then up as their cross product); in_ready stays low while it runs.
module look_at_perspective_projection_core #(
  parameter int unsigned SCREEN_WIDTH  = lapp_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = lapp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [lapp_pkg::CW-1:0]   in_world_x,
  input  logic signed [lapp_pkg::CW-1:0]   in_world_y,
  input  logic signed [lapp_pkg::CW-1:0]   in_world_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_visible,
  output logic signed [lapp_pkg::CW-1:0]   out_screen_x,
  output logic signed [lapp_pkg::CW-1:0]   out_screen_y,
  output logic [lapp_pkg::CW-2:0]          out_depth,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [lapp_pkg::CW-1:0]          cfg_wdata
);

  localparam int unsigned CW   = lapp_pkg::CW;
  localparam int unsigned DW   = lapp_pkg::DW;
  localparam int unsigned BW   = lapp_pkg::BW;
  localparam int unsigned PW   = lapp_pkg::PW;
  localparam int unsigned XW   = lapp_pkg::XW;
  localparam int unsigned ZW   = XW - 1;
  localparam int unsigned RW   = XW;
  localparam int unsigned WB   = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned MW   = XW + WB;
  localparam int unsigned QB   = lapp_pkg::QB;
  localparam int unsigned LOWB = QB - lapp_pkg::Q_FRAC;
  localparam int unsigned ND   = QB / lapp_pkg::DIV_STEPS;
  localparam int unsigned SXW  = QB + 3;
  localparam int unsigned PROD_FRAC = 16;
  localparam int unsigned DEPTH_SHIFT = 14;
  localparam logic signed [SXW-1:0] OFFX = SXW'(SCREEN_WIDTH * 32768);
  localparam logic signed [SXW-1:0] OFFY = SXW'(SCREEN_HEIGHT * 32768);
  localparam logic signed [SXW-1:0] SAT_HI = SXW'(64'sh7FFF_FFFF);
  localparam logic signed [SXW-1:0] SAT_LO = -SAT_HI - SXW'(1);
  localparam logic [ZW-DEPTH_SHIFT-1:0] DEPTH_MAX = (ZW-DEPTH_SHIFT)'(64'h7FFF_FFFF);
  localparam logic signed [PW-1:0] RND16 = PW'((64'd1 << PROD_FRAC) - 64'd1);

  typedef struct packed {
    logic            vis;
    logic            nx;
    logic            ny;
    logic            cx;
    logic            cy;
    logic [ZW-1:0]   z;
    logic [RW-1:0]   rx;
    logic [RW-1:0]   ry;
    logic [LOWB-1:0] lx;
    logic [LOWB-1:0] ly;
    logic [QB-1:0]   qx;
    logic [QB-1:0]   qy;
  } dv_t;

  function automatic dv_t div_step(dv_t d);
    dv_t           o;
    logic [RW-1:0] rsx;
    logic [RW-1:0] rsy;
    int            s;
    o = d;
    for (s = 0; s < lapp_pkg::DIV_STEPS; s++) begin
      rsx  = {o.rx[RW-2:0], o.lx[LOWB-1]};
      rsy  = {o.ry[RW-2:0], o.ly[LOWB-1]};
      o.lx = {o.lx[LOWB-2:0], 1'b0};
      o.ly = {o.ly[LOWB-2:0], 1'b0};
      if (rsx >= RW'(o.z)) begin
        o.rx = rsx - RW'(o.z);
        o.qx = {o.qx[QB-2:0], 1'b1};
      end else begin
        o.rx = rsx;
        o.qx = {o.qx[QB-2:0], 1'b0};
      end
      if (rsy >= RW'(o.z)) begin
        o.ry = rsy - RW'(o.z);
        o.qy = {o.qy[QB-2:0], 1'b1};
      end else begin
        o.ry = rsy;
        o.qy = {o.qy[QB-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [2:0][CW-1:0] cam_r;
  logic [2:0][CW-1:0] look_r;
  logic               busy;
  lapp_pkg::basis_t   basis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r     <= '0;
      look_r[0] <= '0;
      look_r[1] <= '0;
      look_r[2] <= CW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        lapp_pkg::REG_CAM_X:  cam_r[0]  <= cfg_wdata;
        lapp_pkg::REG_CAM_Y:  cam_r[1]  <= cfg_wdata;
        lapp_pkg::REG_CAM_Z:  cam_r[2]  <= cfg_wdata;
        lapp_pkg::REG_LOOK_X: look_r[0] <= cfg_wdata;
        lapp_pkg::REG_LOOK_Y: look_r[1] <= cfg_wdata;
        lapp_pkg::REG_LOOK_Z: look_r[2] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lapp_basis u_basis (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cam     (cam_r),
    .look    (look_r),
    .busy    (busy),
    .basis   (basis)
  );

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;
  logic ds_v_r [ND];
  logic out_valid_r;
  logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f;
  logic adv_ds [ND];

  logic signed [DW-1:0] a_rel_r [3];
  logic signed [PW-1:0] b_p_r   [9];
  logic signed [XW-1:0] c_x_r, c_y_r, c_z_r;
  logic                 d_vis_r, d_nx_r, d_ny_r;
  logic [MW-1:0]        d_mx_r, d_my_r;
  logic [ZW-1:0]        d_z_r;
  dv_t                  e_r;
  dv_t                  ds_r [ND];
  logic                 out_visible_r;
  logic signed [CW-1:0] out_screen_x_r, out_screen_y_r;
  logic [CW-2:0]        out_depth_r;

  assign adv_f = !out_valid_r || out_ready;
  assign adv_ds[ND-1] = !ds_v_r[ND-1] || adv_f;
  for (genvar k = 0; k < ND - 1; k++) begin : g_adv
    assign adv_ds[k] = !ds_v_r[k] || adv_ds[k+1];
  end
  assign adv_e = !e_v_r || adv_ds[0];
  assign adv_d = !d_v_r || adv_e;
  assign adv_c = !c_v_r || adv_d;
  assign adv_b = !b_v_r || adv_c;
  assign adv_a = !a_v_r || adv_b;
  assign in_ready = !busy && adv_a;

  logic signed [DW-1:0] rel_c [3];
  logic signed [BW-1:0] bsel  [9];
  logic signed [PW-1:0] p_c   [9];
  logic signed [PW-1:0] adj   [9];
  logic signed [XW-1:0] t16   [9];
  logic signed [XW-1:0] x_c, y_c, z_c;
  logic [XW-1:0]        magx, magy;
  dv_t                  e_c;
  logic [MW-1:0]        hi_x, hi_y;

  always_comb begin
    rel_c[0] = DW'(in_world_x) - DW'($signed(cam_r[0]));
    rel_c[1] = DW'(in_world_y) - DW'($signed(cam_r[1]));
    rel_c[2] = DW'(in_world_z) - DW'($signed(cam_r[2]));
    for (int j = 0; j < 3; j++) begin
      bsel[j]     = $signed(basis.rgt[j]);
      bsel[3 + j] = $signed(basis.up[j]);
      bsel[6 + j] = $signed(basis.fwd[j]);
    end
    for (int i = 0; i < 9; i++) begin
      p_c[i] = PW'(a_rel_r[i % 3]) * PW'(bsel[i]);
      adj[i] = b_p_r[i] + (b_p_r[i][PW-1] ? RND16 : '0);
      t16[i] = XW'(adj[i] >>> PROD_FRAC);
    end
    x_c = t16[0] + t16[1] + t16[2];
    y_c = t16[3] + t16[4] + t16[5];
    z_c = t16[6] + t16[7] + t16[8];
    magx = c_x_r[XW-1] ? XW'(-c_x_r) : XW'(c_x_r);
    magy = c_y_r[XW-1] ? XW'(-c_y_r) : XW'(c_y_r);

    hi_x = d_mx_r >> LOWB;
    hi_y = d_my_r >> LOWB;
    e_c.vis = d_vis_r;
    e_c.nx  = d_nx_r;
    e_c.ny  = d_ny_r;
    e_c.cx  = hi_x >= MW'(d_z_r);
    e_c.cy  = hi_y >= MW'(d_z_r);
    e_c.z   = d_z_r;
    e_c.rx  = RW'(hi_x);
    e_c.ry  = RW'(hi_y);
    e_c.lx  = d_mx_r[LOWB-1:0];
    e_c.ly  = d_my_r[LOWB-1:0];
    e_c.qx  = '0;
    e_c.qy  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r <= in_valid && in_ready;
      if (adv_b) b_v_r <= a_v_r;
      if (adv_c) c_v_r <= b_v_r;
      if (adv_d) d_v_r <= c_v_r;
      if (adv_e) e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int j = 0; j < 3; j++) a_rel_r[j] <= rel_c[j];
    end
    if (adv_b) begin
      for (int i = 0; i < 9; i++) b_p_r[i] <= p_c[i];
    end
    if (adv_c) begin
      c_x_r <= x_c;
      c_y_r <= y_c;
      c_z_r <= z_c;
    end
    if (adv_d) begin
      d_vis_r <= basis.ok && (c_z_r >= lapp_pkg::NEAR_Z);
      d_nx_r  <= c_x_r[XW-1];
      d_ny_r  <= c_y_r[XW-1];
      d_mx_r  <= MW'(magx) * MW'(SCREEN_WIDTH);
      d_my_r  <= MW'(magy) * MW'(SCREEN_WIDTH);
      d_z_r   <= ZW'(c_z_r);
    end
    if (adv_e) e_r <= e_c;
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ds_v_r[k] <= 1'b0;
        end else if (adv_ds[k]) begin
          ds_v_r[k] <= e_v_r;
        end
      end
      always_ff @(posedge clk) begin
        if (adv_ds[k]) ds_r[k] <= div_step(e_r);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ds_v_r[k] <= 1'b0;
        end else if (adv_ds[k]) begin
          ds_v_r[k] <= ds_v_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv_ds[k]) ds_r[k] <= div_step(ds_r[k-1]);
      end
    end
  end

  dv_t                           f;
  logic [QB:0]                   res_x, res_y;
  logic signed [SXW-1:0]         sx, sy;
  logic [ZW-DEPTH_SHIFT-1:0]     dz;
  logic signed [CW-1:0]          sx_sat, sy_sat;
  logic [CW-2:0]                 dz_sat;

  always_comb begin
    f     = ds_r[ND-1];
    res_x = f.cx ? {1'b1, QB'(0)} : {1'b0, f.qx};
    res_y = f.cy ? {1'b1, QB'(0)} : {1'b0, f.qy};
    sx    = f.nx ? OFFX - SXW'(res_x) : OFFX + SXW'(res_x);
    sy    = f.ny ? OFFY + SXW'(res_y) : OFFY - SXW'(res_y);
    sx_sat = (sx > SAT_HI) ? CW'(SAT_HI) : (sx < SAT_LO) ? CW'(SAT_LO) : CW'(sx);
    sy_sat = (sy > SAT_HI) ? CW'(SAT_HI) : (sy < SAT_LO) ? CW'(SAT_LO) : CW'(sy);
    dz     = (ZW-DEPTH_SHIFT)'(f.z >> DEPTH_SHIFT);
    dz_sat = (dz > DEPTH_MAX) ? (CW-1)'(DEPTH_MAX) : (CW-1)'(dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_f) begin
      out_valid_r <= ds_v_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f) begin
      out_visible_r  <= f.vis;
      out_screen_x_r <= f.vis ? sx_sat : '0;
      out_screen_y_r <= f.vis ? sy_sat : '0;
      out_depth_r    <= f.vis ? dz_sat : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;
  assign out_depth    = out_depth_r;

endmodule
`default_nettype wire

### verif/tb_top.sv
module tb_top;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint HALF_Q30 = 64'sd1 << 29;
  localparam longint NEAR_Q30 = 64'sd10737418;
  localparam longint RATIO_MAX = 64'sd1 << 40;
  localparam longint SW = 800;
  localparam longint SH = 600;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
  } point_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [30:0] depth;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [lapp_pkg::CW-1:0] in_world_x = '0;
  logic signed [lapp_pkg::CW-1:0] in_world_y = '0;
  logic signed [lapp_pkg::CW-1:0] in_world_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic signed [lapp_pkg::CW-1:0] out_screen_x;
  logic signed [lapp_pkg::CW-1:0] out_screen_y;
  logic [lapp_pkg::CW-2:0] out_depth;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [lapp_pkg::CW-1:0] cfg_wdata = '0;

  point_t pending_pts[$];
  pixel_t expected_px[$];
  longint cam[3];
  longint look[3];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit failed = 1'b0;

  look_at_perspective_projection_core u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = mag(a);
    if (mag(b) > m) m = mag(b);
    if (mag(c) > m) m = mag(c);
    return m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void normalize(input longint a0, a1, a2, output longint o0, o1, o2);
    longint len;
    longint unsigned s;
    while (max3(a0, a1, a2) >= ONE_Q30) begin
      a0 = a0 / 2; a1 = a1 / 2; a2 = a2 / 2;
    end
    while (max3(a0, a1, a2) < HALF_Q30) begin
      a0 = a0 * 2; a1 = a1 * 2; a2 = a2 * 2;
    end
    s = a0 * a0 + a1 * a1 + a2 * a2;
    len = longint'(int_sqrt(s));
    o0 = a0 * ONE_Q30 / len;
    o1 = a1 * ONE_Q30 / len;
    o2 = a2 * ONE_Q30 / len;
  endfunction

  function automatic longint dot_q30(longint r0, r1, r2, b0, b1, b2);
    return (r0 * b0) / 65536 + (r1 * b1) / 65536 + (r2 * b2) / 65536;
  endfunction

  function automatic longint pixel_offset(longint n, longint z);
    longint unsigned m, q, rem, res;
    m = longint'(mag(n)) * SW;
    q = m / z;
    rem = m % z;
    if (q >= (64'd1 << 25)) res = RATIO_MAX;
    else res = (q << 15) + (rem << 15) / z;
    if (res > RATIO_MAX) res = RATIO_MAX;
    return n < 0 ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t px;
    longint d0, d1, d2, f0, f1, f2, r0, r1, r2, u0, u1, u2;
    longint e0, e1, e2, x, y, z, dz;
    px = '0;
    d0 = look[0] - cam[0];
    d1 = look[1] - cam[1];
    d2 = look[2] - cam[2];
    if (d0 == 0 && d2 == 0) return px;
    normalize(d0, d1, d2, f0, f1, f2);
    normalize(d2, 0, -d0, r0, r1, r2);
    u0 = (f1 * r2) / ONE_Q30;
    u1 = (f2 * r0 - f0 * r2) / ONE_Q30;
    u2 = (-f1 * r0) / ONE_Q30;
    e0 = longint'($signed(p.wx)) - cam[0];
    e1 = longint'($signed(p.wy)) - cam[1];
    e2 = longint'($signed(p.wz)) - cam[2];
    x = dot_q30(e0, e1, e2, r0, r1, r2);
    y = dot_q30(e0, e1, e2, u0, u1, u2);
    z = dot_q30(e0, e1, e2, f0, f1, f2);
    if (z < NEAR_Q30) return px;
    dz = z / 16384;
    if (dz > 64'sd2147483647) dz = 64'sd2147483647;
    px.visible = 1'b1;
    px.sx = clamp32(pixel_offset(x, z) + SW * 32768);
    px.sy = clamp32(SH * 32768 - pixel_offset(y, z));
    px.depth = dz[30:0];
    return px;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_px.push_back(project_point({in_world_x, in_world_y, in_world_z}));
      if (!in_valid || in_ready) begin
        if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_pts.pop_front();
          in_world_x <= p.wx;
          in_world_y <= p.wy;
          in_world_z <= p.wz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $display("%0t unexpected beat: visible %0d x %h y %h depth %h", $time,
                 out_visible, out_screen_x, out_screen_y, out_depth);
        failed = 1'b1;
      end else begin
        pixel_t e;
        e = expected_px.pop_front();
        if (out_visible !== e.visible) begin
          $display("%0t visible: expected %0d actual %0d", $time, e.visible, out_visible);
          failed = 1'b1;
        end
        if (out_screen_x !== e.sx) begin
          $display("%0t screen_x: expected %h actual %h", $time, e.sx, out_screen_x);
          failed = 1'b1;
        end
        if (out_screen_y !== e.sy) begin
          $display("%0t screen_y: expected %h actual %h", $time, e.sy, out_screen_y);
          failed = 1'b1;
        end
        if (out_depth !== e.depth) begin
          $display("%0t depth: expected %h actual %h", $time, e.depth, out_depth);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      lapp_pkg::REG_CAM_X:  cam[0] = longint'($signed(d));
      lapp_pkg::REG_CAM_Y:  cam[1] = longint'($signed(d));
      lapp_pkg::REG_CAM_Z:  cam[2] = longint'($signed(d));
      lapp_pkg::REG_LOOK_X: look[0] = longint'($signed(d));
      lapp_pkg::REG_LOOK_Y: look[1] = longint'($signed(d));
      lapp_pkg::REG_LOOK_Z: look[2] = longint'($signed(d));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [31:0] cx, cy, cz, lx, ly, lz);
    write_reg(lapp_pkg::REG_CAM_X, cx);
    write_reg(lapp_pkg::REG_CAM_Y, cy);
    write_reg(lapp_pkg::REG_CAM_Z, cz);
    write_reg(lapp_pkg::REG_LOOK_X, lx);
    write_reg(lapp_pkg::REG_LOOK_Y, ly);
    write_reg(lapp_pkg::REG_LOOK_Z, lz);
  endtask

  task automatic drain();
    while (pending_pts.size() > 0 || in_valid || expected_px.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] jitter(longint base, int unsigned span);
    longint off;
    off = longint'($urandom_range(2 * span)) - longint'(span);
    return 32'(base + off);
  endfunction

  task automatic random_points(int n);
    point_t p;
    int unsigned span;
    for (int i = 0; i < n; i++) begin
      span = (i % 4 == 0) ? 32'h00FF_FFFF : 32'h0003_FFFF;
      if ($urandom_range(9) < 2) begin
        p = {$urandom, $urandom, $urandom};
      end else begin
        p.wx = jitter(look[0] + (look[0] - cam[0]), span);
        p.wy = jitter(look[1] + (look[1] - cam[1]), span);
        p.wz = jitter(look[2] + (look[2] - cam[2]), span);
      end
      pending_pts.push_back(p);
    end
  endtask

  task automatic random_camera(bit full);
    if (full) begin
      set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      set_camera(jitter(0, 32'h0064_0000), jitter(0, 32'h0064_0000),
                 jitter(0, 32'h0064_0000), jitter(0, 32'h0064_0000),
                 jitter(0, 32'h0064_0000), jitter(0, 32'h0064_0000));
    end
  endtask

  initial begin
    cam[0] = 0; cam[1] = 0; cam[2] = 0;
    look[0] = 0; look[1] = 0; look[2] = 65536;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    pending_pts.push_back({32'h0, 32'h0, 32'h0001_0000});
    pending_pts.push_back({32'h0, 32'h0, 32'd655});
    pending_pts.push_back({32'h0, 32'h0, 32'd656});
    pending_pts.push_back({32'h0, 32'h0, 32'hFFFF_0000});
    pending_pts.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pts.push_back({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_pts.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'd656});
    pending_pts.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'd700});
    pending_pts.push_back({32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000});
    pending_pts.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    drain();

    set_camera(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0005_0000,
               32'h0001_0000);
    pending_pts.push_back({32'h0, 32'h0, 32'h0});
    pending_pts.push_back({32'h0001_0000, 32'h0009_0000, 32'h0001_0000});
    drain();
    set_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    pending_pts.push_back({32'h0, 32'h0, 32'h0001_0000});
    drain();
    set_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
    pending_pts.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pts.push_back({32'h0, 32'h0, 32'h0});
    pending_pts.push_back({32'h8000_0000, 32'h0, 32'h7FFF_FFFF});
    drain();
    set_camera(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    pending_pts.push_back({32'h8000_0000, 32'h0001_0000, 32'h0});
    pending_pts.push_back({32'h0, 32'h0, 32'h0});
    drain();
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    pending_pts.push_back({32'h0, 32'h0, 32'h0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph == 7) set_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      else random_camera(ph == 5);
      random_points(55);
      while (pending_pts.size() > 0 || in_valid || expected_px.size() > 0) @(posedge clk);
      random_points(55);
      drain();
    end

    if (!failed) $display("PASS look_at_perspective_projection_core");
    else $display("FAIL look_at_perspective_projection_core");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL look_at_perspective_projection_core");
    $finish;
  end

endmodule

### sim.f
rtl/lapp_pkg.sv
rtl/lapp_basis.sv
rtl/look_at_perspective_projection_core.sv
verif/tb_top.sv
